// ===== rtl/tts_pkg.sv =====
// Shared types, field widths and character codes for the tile screen terminal.
package tts_pkg;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int TILE_W     = 16;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 5;
    localparam int COLOR_W    = 4;
    localparam int ARG_W      = 2;
    localparam int COLS_CFG_W = 7;
    localparam int ROWS_CFG_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [COLS_CFG_W-1:0] RESET_COLS  = 7'd40;
    localparam logic [ROWS_CFG_W-1:0] RESET_ROWS  = 6'd13;
    localparam logic [TILE_W-1:0]     RESET_BLANK = 16'd544;

    // Tile word layout
    localparam int                    COLOR_SHIFT  = 11;
    localparam int                    PARITY_SHIFT = 10;
    localparam logic [TILE_W-1:0]     TILE_BASE    = 16'h0200;
    localparam logic [CHAR_W-1:0]     PAIR_MASK    = 8'hFE;
    localparam logic [CHAR_W-1:0]     SPACE_CHAR   = 8'h20;
    localparam int                    TAB_STOP     = 8;

    // Terminal control codes
    localparam logic [CHAR_W-1:0] CH_CLEAR    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_HOME     = 8'd1;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SET_COL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SET_ROW  = 8'd11;
    localparam logic [CHAR_W-1:0] CH_SET_CLR  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd13;

    // Stdio control characters
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS  = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_CODES = 2'd2,
        CFG_BLANK = 2'd3
    } cfg_idx_t;

    typedef enum logic [ARG_W-1:0] {
        ARG_NONE  = 2'd0,
        ARG_COL   = 2'd1,
        ARG_ROW   = 2'd2,
        ARG_COLOR = 2'd3
    } arg_t;

    typedef enum logic [3:0] {
        OP_READ     = 4'd0,
        OP_CLEAR    = 4'd1,
        OP_HOME     = 4'd2,
        OP_BACK     = 4'd3,
        OP_TAB      = 4'd4,
        OP_ARG      = 4'd5,
        OP_NEWLINE  = 4'd6,
        OP_CR       = 4'd7,
        OP_PRINT    = 4'd8,
        OP_SETCOL   = 4'd9,
        OP_SETROW   = 4'd10,
        OP_SETCOLOR = 4'd11
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_item;
        logic load_tile;
        logic home;
        logic back;
        logic cr;
        logic arg_sel;
        logic set_color;
        logic rem_start;
        logic set_arg;
        logic print;
        logic newline;
        logic clear_start;
        logic sweep_run;
        logic result_load;
    } tts_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic wrap;
        logic tab_more;
        logic need_scroll;
        logic sweep_done;
        logic rem_busy;
        logic out_busy;
    } tts_stat_t;

endpackage

// ===== rtl/tts_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module tts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tts_rem.sv =====
// Bit-serial remainder unit: one dividend bit per cycle (restoring).
module tts_rem #(
    parameter int DW = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tts_pkg::CHAR_W-1:0] dividend,
    input  logic [DW-1:0]             divisor,
    output logic                      busy,
    output logic [DW-1:0]             remainder
);
    import tts_pkg::*;

    localparam int              SW        = $clog2(CHAR_W);
    localparam logic [SW-1:0]   LAST_STEP = SW'(CHAR_W - 1);

    logic              busy_reg, busy_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [CHAR_W-1:0] dvd_reg,  dvd_next;
    logic [DW-1:0]     dsr_reg,  dsr_next;
    logic [DW-1:0]     rem_reg,  rem_next;
    logic [DW:0]       trial;
    logic [DW:0]       diff;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, dvd_reg[CHAR_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = (trial >= {1'b0, dsr_reg}) ? diff[DW-1:0] : trial[DW-1:0];
            dvd_next  = dvd_reg << 1;
            step_next = step_reg + SW'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/tts_dp.sv =====
// Datapath: config registers, cursor state, screen RAM, sweep engine, result register.
module tts_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  tts_pkg::cfg_idx_t             cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          action,
    input  logic [tts_pkg::CHAR_W-1:0]    char_code,
    input  logic [tts_pkg::COL_W-1:0]     read_col,
    input  logic [tts_pkg::ROW_W-1:0]     read_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tts_pkg::TILE_W-1:0]    tile_word,
    output logic [tts_pkg::COL_W-1:0]     cursor_col,
    output logic [tts_pkg::ROW_W-1:0]     cursor_row,
    output logic [tts_pkg::COLOR_W-1:0]   color_index,
    output logic [tts_pkg::ARG_W-1:0]     arg_pending,
    input  tts_pkg::tts_cmd_t             cmd,
    output tts_pkg::tts_stat_t            stat
);
    import tts_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int ERW   = $clog2(MAX_ROWS + 1);
    localparam int DW    = (ECW > ERW) ? ECW : ERW;
    localparam int PW    = ECW + ((RW > ROW_W) ? RW : ROW_W) + 1;
    localparam int CXW   = (COLS_CFG_W > ECW) ? COLS_CFG_W : ECW;
    localparam int RXW   = (ROWS_CFG_W > ERW) ? ROWS_CFG_W : ERW;

    // Configuration registers
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic                  code_set_reg;
    logic [TILE_W-1:0]     blank_reg;

    // Terminal state
    logic [CW-1:0]      col_reg,   col_next;
    logic [RW-1:0]      row_reg,   row_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    arg_t               pend_reg,  pend_next;

    // Captured item
    logic              it_action_reg;
    logic [CHAR_W-1:0] it_char_reg;
    logic [COL_W-1:0]  it_rc_reg;
    logic [ROW_W-1:0]  it_rr_reg;
    logic [TILE_W-1:0] tile_reg, tile_next;

    // Sweep engine (clear, scroll, power-up fill)
    logic [CNTW-1:0]   swp_cnt_reg,  swp_cnt_next;
    logic [CNTW-1:0]   swp_end_reg,  swp_end_next;
    logic              swp_copy_reg, swp_copy_next;
    logic [TILE_W-1:0] swp_fill_reg, swp_fill_next;
    logic              wr_pend_reg,  wr_pend_next;
    logic [AW-1:0]     wr_addr_reg,  wr_addr_next;
    logic              wr_copy_reg,  wr_copy_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [TILE_W-1:0]  o_tile_reg;
    logic [COL_W-1:0]   o_col_reg;
    logic [ROW_W-1:0]   o_row_reg;
    logic [COLOR_W-1:0] o_color_reg;
    logic [ARG_W-1:0]   o_arg_reg;

    logic [CXW-1:0]    cols_x;
    logic [RXW-1:0]    rows_x;
    logic [ECW-1:0]    eff_cols;
    logic [ERW-1:0]    eff_rows;
    op_t               op;
    arg_t              arg_code;
    logic [PW-1:0]     col_p1, row_p1;
    logic              wrap, need_scroll, tab_more;
    logic              pr_in_range, rd_in_range;
    logic [AW-1:0]     pr_addr, rd_addr, swp_raddr;
    logic [CNTW-1:0]   area, copy_lim;
    logic              swp_active, do_nl, swp_start;
    logic [CHAR_W-1:0] pr_char;
    logic [TILE_W-1:0] glyph, clear_fill;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [TILE_W-1:0] ram_wdata, ram_rdata;
    logic [DW-1:0]     rem_divisor, rem_val;
    logic              rem_busy;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= RESET_COLS;
            rows_cfg_reg <= RESET_ROWS;
            code_set_reg <= 1'b0;
            blank_reg    <= RESET_BLANK;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLS:  cols_cfg_reg <= cfg_data[COLS_CFG_W-1:0];
                CFG_ROWS:  rows_cfg_reg <= cfg_data[ROWS_CFG_W-1:0];
                CFG_CODES: code_set_reg <= cfg_data[0];
                CFG_BLANK: blank_reg    <= cfg_data[TILE_W-1:0];
            endcase
        end
    end

    // Effective screen size: zero acts as one, oversize clamps to the maximum
    assign cols_x = CXW'(cols_cfg_reg);
    assign rows_x = RXW'(rows_cfg_reg);

    always_comb
    begin
        priority if (cols_x == '0)
            eff_cols = ECW'(1);
        else if (cols_x > CXW'(MAX_COLS))
            eff_cols = ECW'(MAX_COLS);
        else
            eff_cols = ECW'(cols_x);
        priority if (rows_x == '0)
            eff_rows = ERW'(1);
        else if (rows_x > RXW'(MAX_ROWS))
            eff_rows = ERW'(MAX_ROWS);
        else
            eff_rows = ERW'(rows_x);
    end

    // Decode the captured item
    always_comb
    begin
        op = OP_PRINT;
        if (it_action_reg)
        begin
            op = OP_READ;
        end
        else if (!code_set_reg)
        begin
            unique case (pend_reg)
                ARG_NONE:
                begin
                    unique case (it_char_reg)
                        CH_CLEAR:   op = OP_CLEAR;
                        CH_HOME:    op = OP_HOME;
                        CH_BS:      op = OP_BACK;
                        CH_TAB:     op = OP_TAB;
                        CH_SET_COL, CH_SET_ROW, CH_SET_CLR: op = OP_ARG;
                        CH_NEWLINE: op = OP_NEWLINE;
                        default:    op = OP_PRINT;
                    endcase
                end
                ARG_COL:   op = OP_SETCOL;
                ARG_ROW:   op = OP_SETROW;
                ARG_COLOR: op = OP_SETCOLOR;
            endcase
        end
        else
        begin
            unique case (it_char_reg)
                CH_BS:   op = OP_BACK;
                CH_TAB:  op = OP_TAB;
                CH_LF:   op = OP_NEWLINE;
                CH_CR:   op = OP_CR;
                default: op = OP_PRINT;
            endcase
        end
    end

    always_comb
    begin
        priority if (it_char_reg == CH_SET_COL)
            arg_code = ARG_COL;
        else if (it_char_reg == CH_SET_ROW)
            arg_code = ARG_ROW;
        else
            arg_code = ARG_COLOR;
    end

    // Cursor arithmetic and addresses
    assign col_p1      = PW'(col_reg) + PW'(1);
    assign row_p1      = PW'(row_reg) + PW'(1);
    assign wrap        = col_p1 >= PW'(eff_cols);
    assign need_scroll = row_p1 >= PW'(eff_rows);
    assign tab_more    = (col_p1 & PW'(TAB_STOP - 1)) != '0;
    assign pr_in_range = (PW'(col_reg) < PW'(eff_cols)) && (PW'(row_reg) < PW'(eff_rows));
    assign rd_in_range = (PW'(it_rc_reg) < PW'(eff_cols)) && (PW'(it_rr_reg) < PW'(eff_rows));
    assign pr_addr     = AW'(PW'(row_reg) * PW'(eff_cols) + PW'(col_reg));
    assign rd_addr     = AW'(PW'(it_rr_reg) * PW'(eff_cols) + PW'(it_rc_reg));
    assign area        = CNTW'(PW'(eff_rows) * PW'(eff_cols));

    // Tile words
    assign pr_char    = (op == OP_TAB) ? SPACE_CHAR : it_char_reg;
    assign glyph      = ((TILE_W'(color_reg) << COLOR_SHIFT)
                         | (TILE_W'(pr_char[0]) << PARITY_SHIFT))
                        + TILE_BASE + TILE_W'(pr_char & PAIR_MASK);
    assign clear_fill = (TILE_W'(color_reg) << COLOR_SHIFT) | blank_reg;

    // Sweep: read the cell one row ahead, write it into the row above in the next cycle
    assign copy_lim   = swp_end_reg - CNTW'(eff_cols);
    assign swp_active = cmd.sweep_run && (swp_cnt_reg < swp_end_reg);
    assign swp_raddr  = AW'(swp_cnt_reg + CNTW'(eff_cols));
    assign do_nl      = cmd.newline || (cmd.print && wrap);
    assign swp_start  = cmd.clear_start || (do_nl && need_scroll);

    always_comb
    begin
        swp_cnt_next  = swp_cnt_reg;
        swp_end_next  = swp_end_reg;
        swp_copy_next = swp_copy_reg;
        swp_fill_next = swp_fill_reg;
        if (swp_start)
        begin
            swp_cnt_next  = '0;
            swp_end_next  = area;
            swp_copy_next = !cmd.clear_start;
            swp_fill_next = cmd.clear_start ? clear_fill : blank_reg;
        end
        else if (swp_active)
        begin
            swp_cnt_next = swp_cnt_reg + CNTW'(1);
        end
        wr_pend_next = swp_active;
        wr_addr_next = swp_cnt_reg[AW-1:0];
        wr_copy_next = swp_copy_reg && (swp_cnt_reg < copy_lim);
    end

    // Screen RAM port muxing
    always_comb
    begin
        if (wr_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = wr_copy_reg ? ram_rdata : swp_fill_reg;
        end
        else
        begin
            ram_we    = cmd.print && pr_in_range;
            ram_waddr = pr_addr;
            ram_wdata = glyph;
        end
        ram_raddr = cmd.rd_item ? rd_addr : swp_raddr;
    end

    tts_ram #(
        .WIDTH (TILE_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Argument modulo
    assign rem_divisor = (op == OP_SETCOL) ? DW'(eff_cols) : DW'(eff_rows);

    tts_rem #(
        .DW (DW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rem_start),
        .dividend  (it_char_reg),
        .divisor   (rem_divisor),
        .busy      (rem_busy),
        .remainder (rem_val)
    );

    // Cursor, color and argument updates
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        color_next = color_reg;
        pend_next  = pend_reg;
        if (cmd.home || cmd.clear_start)
        begin
            col_next = '0;
            row_next = '0;
        end
        if (cmd.back && (col_reg != '0))
        begin
            col_next = col_reg - CW'(1);
        end
        if (cmd.cr)
        begin
            col_next = '0;
        end
        if (cmd.arg_sel)
        begin
            pend_next = arg_code;
        end
        if (cmd.set_color)
        begin
            color_next = it_char_reg[COLOR_W-1:0];
            pend_next  = ARG_NONE;
        end
        if (cmd.set_arg)
        begin
            if (op == OP_SETCOL)
                col_next = CW'(rem_val);
            else
                row_next = RW'(rem_val);
            pend_next = ARG_NONE;
        end
        if (cmd.print && !wrap)
        begin
            col_next = CW'(col_p1);
        end
        if (do_nl)
        begin
            col_next = '0;
            row_next = need_scroll ? RW'(eff_rows - ERW'(1)) : RW'(row_p1);
        end
    end

    // Tile of the current item
    always_comb
    begin
        tile_next = tile_reg;
        if (cmd.capture)
            tile_next = '0;
        else if (cmd.load_tile)
            tile_next = rd_in_range ? ram_rdata : '0;
    end

    // Output register: a new beat loads as the old one leaves
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            color_reg     <= '0;
            pend_reg      <= ARG_NONE;
            swp_cnt_reg   <= '0;
            swp_end_reg   <= CNTW'(CELLS);
            swp_copy_reg  <= 1'b0;
            swp_fill_reg  <= RESET_BLANK;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            color_reg     <= color_next;
            pend_reg      <= pend_next;
            swp_cnt_reg   <= swp_cnt_next;
            swp_end_reg   <= swp_end_next;
            swp_copy_reg  <= swp_copy_next;
            swp_fill_reg  <= swp_fill_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            it_action_reg <= action;
            it_char_reg   <= char_code;
            it_rc_reg     <= read_col;
            it_rr_reg     <= read_row;
        end
        tile_reg    <= tile_next;
        wr_addr_reg <= wr_addr_next;
        wr_copy_reg <= wr_copy_next;
        if (cmd.result_load)
        begin
            o_tile_reg  <= tile_reg;
            o_col_reg   <= COL_W'(col_reg);
            o_row_reg   <= ROW_W'(row_reg);
            o_color_reg <= color_reg;
            o_arg_reg   <= pend_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tile_word   = o_tile_reg;
    assign cursor_col  = o_col_reg;
    assign cursor_row  = o_row_reg;
    assign color_index = o_color_reg;
    assign arg_pending = o_arg_reg;

    assign stat.op          = op;
    assign stat.wrap        = wrap;
    assign stat.tab_more    = tab_more;
    assign stat.need_scroll = need_scroll;
    assign stat.sweep_done  = (swp_cnt_reg == swp_end_reg) && !wr_pend_reg;
    assign stat.rem_busy    = rem_busy;
    assign stat.out_busy    = out_valid_reg && out_stall;

endmodule

// ===== rtl/tts_ctrl.sv =====
// Controller: sequences one item at a time through the datapath.
module tts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tts_pkg::tts_stat_t  stat,
    output tts_pkg::tts_cmd_t   cmd
);
    import tts_pkg::*;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_PRINT  = 8'b0001_0000,
        S_MOD    = 8'b0010_0000,
        S_SWEEP  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            // Power-up fill of the screen memory
            S_INIT:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_READ:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = S_READ;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_start = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    OP_HOME:
                    begin
                        cmd.home   = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_BACK:
                    begin
                        cmd.back   = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_CR:
                    begin
                        cmd.cr     = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_ARG:
                    begin
                        cmd.arg_sel = 1'b1;
                        state_next  = S_DONE;
                    end
                    OP_SETCOLOR:
                    begin
                        cmd.set_color = 1'b1;
                        state_next    = S_DONE;
                    end
                    OP_SETCOL, OP_SETROW:
                    begin
                        cmd.rem_start = 1'b1;
                        state_next    = S_MOD;
                    end
                    OP_TAB, OP_PRINT:
                    begin
                        state_next = S_PRINT;
                    end
                    OP_NEWLINE:
                    begin
                        cmd.newline = 1'b1;
                        state_next  = stat.need_scroll ? S_SWEEP : S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.load_tile = 1'b1;
                state_next    = S_DONE;
            end
            // One cell per cycle; tab repeats until the next tab stop or a line wrap
            S_PRINT:
            begin
                cmd.print = 1'b1;
                priority if (stat.wrap && stat.need_scroll)
                    state_next = S_SWEEP;
                else if (stat.wrap)
                    state_next = S_DONE;
                else if ((stat.op == OP_TAB) && stat.tab_more)
                    state_next = S_PRINT;
                else
                    state_next = S_DONE;
            end
            S_MOD:
            begin
                if (!stat.rem_busy)
                begin
                    cmd.set_arg = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/text_terminal_tile_screen.sv =====
// Tile screen text terminal, one item at a time. After decode, a read reads the screen RAM; a
// print writes one cell, and a tab writes one space per step up to the next tab stop (1 to 8
// spaces); a column or row argument waits for the 8-step remainder. Clear and a scroll add a
// sweep over the screen. The next beat is taken in the cycle after the result loads; a stalled
// result holds the controller. Reset clears cursor, color and argument, then fills the screen
// RAM with the reset blank word, input stalled until the fill is done.
module text_terminal_tile_screen #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  tts_pkg::cfg_idx_t             cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [tts_pkg::CHAR_W-1:0]    char_code,
    input  logic [tts_pkg::COL_W-1:0]     read_col,
    input  logic [tts_pkg::ROW_W-1:0]     read_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tts_pkg::TILE_W-1:0]    tile_word,
    output logic [tts_pkg::COL_W-1:0]     cursor_col,
    output logic [tts_pkg::ROW_W-1:0]     cursor_row,
    output logic [tts_pkg::COLOR_W-1:0]   color_index,
    output logic [tts_pkg::ARG_W-1:0]     arg_pending
);
    import tts_pkg::*;

    tts_cmd_t  cmd;
    tts_stat_t stat;

    tts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tts_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .char_code   (char_code),
        .read_col    (read_col),
        .read_row    (read_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tile_word   (tile_word),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .color_index (color_index),
        .arg_pending (arg_pending),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
